### hw/rtl/atlp_pkg.sv
// Shared widths, constants and controller/datapath interface types.
package atlp_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int SUM_W     = 16;
   localparam int CNT_W     = 7;
   localparam int REG_W     = 7;
   localparam int PROD_W    = 17;
   localparam int DIV_W     = 17;
   localparam int DIVR_W    = 7;
   localparam int DIV_CNT_W = 5;
   localparam int CSR_W     = 32;
   localparam int ADDR_W    = 3;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 24;

   localparam logic [REG_W-1:0]     AVG_COUNT_RESET     = 7'd30;
   localparam logic [REG_W-1:0]     FILTER_WEIGHT_RESET = 7'd10;
   localparam logic [REG_W-1:0]     WEIGHT_FULL         = 7'd100;
   localparam logic [PROD_W-1:0]    ROUND_HALF          = 17'd50;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS           = 5'd17;
   // ceil(2^24 / 100): exact floor(x / 100) for every x below 2^17
   localparam logic [RECIP_W-1:0]   RECIP_100           = 18'd167773;

   // register index, taken from paddr[2]
   localparam logic REG_AVG_COUNT     = 1'b0;
   localparam logic REG_FILTER_WEIGHT = 1'b1;

   typedef struct packed {
      logic acc_en;
      logic acc_clear;
      logic div_start;
      logic avg_load;
      logic mult_en;
      logic scale_en;
      logic update_en;
   } cmd_type;

   typedef struct packed {
      logic block_full;
      logic div_done;
   } status_type;

endpackage

### hw/rtl/atlp_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module atlp_div
   import atlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVR_W:0]      shifted;
   logic [DIVR_W:0]      trial;
   logic                 fits;

   assign shifted = {rem_ff, quot_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_W-2:0], fits};
         rem_in  = fits ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_STEPS - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### hw/rtl/atlp_datapath.sv
// Accumulator, filter state, multipliers, serial divider and result registers.
module atlp_datapath
   import atlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [REG_W-1:0]    count_eff,
   input  logic [REG_W-1:0]    weight_eff,
   output logic [SAMPLE_W-1:0] average,
   output logic [SAMPLE_W-1:0] filtered
);

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SAMPLE_W-1:0] filter_ff, filter_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                down_ff, down_in;
   logic [SAMPLE_W-1:0] step_ff, step_in;
   logic [SAMPLE_W-1:0] average_ff, average_in;
   logic [SAMPLE_W-1:0] filtered_ff, filtered_in;

   logic [DIV_W-1:0]          div_dividend;
   logic                      div_done;
   logic [DIV_W-1:0]          div_quotient;
   logic                      down;
   logic [SAMPLE_W-1:0]       diff;
   logic [PROD_W+RECIP_W-1:0] scaled;

   assign div_dividend = {1'b0, sum_ff};

   atlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (count_eff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign down = avg_ff < filter_ff;
   assign diff = down ? (filter_ff - avg_ff) : (avg_ff - filter_ff);

   // divide by 100 via reciprocal multiply
   assign scaled = {{RECIP_W{1'b0}}, prod_ff} * {{PROD_W{1'b0}}, RECIP_100};

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      filter_in   = filter_ff;
      avg_in      = avg_ff;
      prod_in     = prod_ff;
      down_in     = down_ff;
      step_in     = step_ff;
      average_in  = average_ff;
      filtered_in = filtered_ff;
      if (cmd.acc_clear) begin
         sum_in   = '0;
         count_in = '0;
      end else if (cmd.acc_en) begin
         sum_in   = sum_ff + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
         count_in = count_ff + 1'b1;
      end
      if (cmd.avg_load)
         avg_in = div_quotient[SAMPLE_W-1:0];
      if (cmd.mult_en) begin
         prod_in = ({{(PROD_W-SAMPLE_W){1'b0}}, diff} *
                    {{(PROD_W-REG_W){1'b0}}, weight_eff}) + ROUND_HALF;
         down_in = down;
      end
      if (cmd.scale_en)
         step_in = scaled[RECIP_SHIFT +: SAMPLE_W];
      if (cmd.update_en) begin
         filter_in   = down_ff ? (filter_ff - step_ff) : (filter_ff + step_ff);
         average_in  = avg_ff;
         filtered_in = filter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         filter_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         filter_ff <= filter_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      prod_ff     <= prod_in;
      down_ff     <= down_in;
      step_ff     <= step_in;
      average_ff  <= average_in;
      filtered_ff <= filtered_in;
   end

   assign status.block_full = count_ff >= count_eff;
   assign status.div_done   = div_done;
   assign average           = average_ff;
   assign filtered          = filtered_ff;

endmodule

### hw/rtl/atlp_ctrl.sv
// Sequencer: accept, block check, average divide, filter step, result beat.
module atlp_ctrl
   import atlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      DIV_AVG,
      MULT,
      SCALE,
      UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.acc_en = 1'b1;
               state_in   = CHECK;
            end
         end
         CHECK: begin
            if (status.block_full) begin
               cmd.div_start = 1'b1;
               cmd.acc_clear = 1'b1;
               state_in      = DIV_AVG;
            end else begin
               state_in = IDLE;
            end
         end
         DIV_AVG: begin
            if (status.div_done) begin
               cmd.avg_load = 1'b1;
               state_in     = MULT;
            end
         end
         MULT: begin
            cmd.mult_en = 1'b1;
            state_in    = SCALE;
         end
         SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = UPDATE;
         end
         UPDATE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update_en = 1'b1;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.update_en)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/average_then_lowpass_filter_top.sv
// Boxcar averager followed by a first-order low-pass filter, with register port.
//
// Each req beat carries one 10-bit converter sample, added to a 16-bit
// running sum (wraps). When the sample count reaches average_count (a
// count of zero acts as one), the block divides the sum by the count to
// get the truncated average, clears sum and count, then moves the stored
// filter value toward that average by filter_weight/100 of the difference
// (weight saturates at 100), the step magnitude rounded half up. One rsp
// beat carries the average and the new filter value; samples that do not
// finish a block produce no rsp beat. A sample that does not finish a
// block passes only the block check; one that finishes a block passes
// the block check, the serial divider for sum / count (17 quotient
// bits), the weighted difference multiply, a reciprocal multiply for
// the divide by 100 and the filter update. A finished result sits in
// an output register, so the next sample is taken while the rsp beat
// waits; only a second finished block stalls until that beat leaves.
// Registers (APB, 32-bit data): 0x0 average_count (7 bits, reset 30),
// 0x4 filter_weight (7 bits, reset 10). Write registers only while the
// block is idle.
module average_then_lowpass_filter_top
   import atlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // sample channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_average,
   output logic [SAMPLE_W-1:0] rsp_filtered,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   logic [REG_W-1:0] avg_count_ff, avg_count_in;
   logic [REG_W-1:0] weight_ff, weight_in;
   logic             csr_write;
   logic             csr_index;
   logic [REG_W-1:0] count_eff;
   logic [REG_W-1:0] weight_eff;
   cmd_type          cmd;
   status_type       status;

   // register file: write on the access phase, index from paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      avg_count_in = avg_count_ff;
      weight_in    = weight_ff;
      if (csr_write) begin
         case (csr_index)
            REG_AVG_COUNT:     avg_count_in = pwdata[REG_W-1:0];
            REG_FILTER_WEIGHT: weight_in    = pwdata[REG_W-1:0];
            default: begin
               avg_count_in = avg_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_count_ff <= AVG_COUNT_RESET;
         weight_ff    <= FILTER_WEIGHT_RESET;
      end else begin
         avg_count_ff <= avg_count_in;
         weight_ff    <= weight_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_AVG_COUNT:     prdata = {{(CSR_W-REG_W){1'b0}}, avg_count_ff};
         REG_FILTER_WEIGHT: prdata = {{(CSR_W-REG_W){1'b0}}, weight_ff};
         default:           prdata = '0;
      endcase
   end

   // zero count acts as one; weight saturates at full scale
   assign count_eff  = (avg_count_ff == '0) ? {{(REG_W-1){1'b0}}, 1'b1} : avg_count_ff;
   assign weight_eff = (weight_ff > WEIGHT_FULL) ? WEIGHT_FULL : weight_ff;

   atlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   atlp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_sample),
      .count_eff  (count_eff),
      .weight_eff (weight_eff),
      .average    (rsp_average),
      .filtered   (rsp_filtered)
   );

endmodule
